// ===== src/rhc_pkg.sv =====
// ----------------------------------------------------------------------------
// rhc_pkg: RGB/HSV converter shared types and constants
// Word layouts, fixed widths and the sideband carried along the pipeline.
// ----------------------------------------------------------------------------
package rhc_pkg;

	localparam int HUE_W  = 11;
	localparam int PIX_W  = 8;
	localparam int FS_W   = 16;              // full scale up to 65535
	localparam int NUM_W  = 32;              // divider dividend width
	localparam int DEN_W  = 24;              // divider divisor width
	localparam int QUO_W  = 9;               // quotient bits (max 256 plus overflow)
	localparam int DIV_LAT = QUO_W + 1;      // divider register count

	localparam logic [HUE_W-1:0] HUE_FULL = 11'd1536;  // six sectors
	localparam logic [HUE_W-1:0] HUE_TWO  = 11'd512;
	localparam logic [HUE_W-1:0] HUE_FOUR = 11'd1024;

	localparam logic FUNC_RGB2HSV = 1'b0;
	localparam logic FUNC_HSV2RGB = 1'b1;

	typedef struct packed {
		logic             func;
		logic [HUE_W-1:0] in_first;
		logic [PIX_W-1:0] in_second;
		logic [PIX_W-1:0] in_third;
	} rhc_in_t;

	typedef struct packed {
		logic [HUE_W-1:0] out_first;
		logic [PIX_W-1:0] out_second;
		logic [PIX_W-1:0] out_third;
	} rhc_out_t;

	typedef struct packed {
		logic             func;
		logic             zero_d;     // grey pixel
		logic             zero_mx;    // black pixel
		logic             lo_ge_hi;
		logic [HUE_W-1:0] base;
		logic [PIX_W-1:0] v;          // max component, or input value
		logic [2:0]       sector;
	} rhc_sb_t;

endpackage

// ===== src/rgb_hsv_color_converter_top.sv =====
// ----------------------------------------------------------------------------
// rgb_hsv_color_converter_top: RGB <-> HSV pixel converter
// Fifteen-stage pipeline: input, prep, products, dividends, divider, result.
// ----------------------------------------------------------------------------
//  channel | signals                          | word
//  in      | in_valid, in_ready, in_data      | rhc_in_t  (func, pixel)
//  out     | out_valid, out_ready, out_data   | rhc_out_t (converted pixel)
//
// One word per cycle sustained while out_ready stays high.
// The depth is set by the three restoring dividers, one quotient bit a stage.
// Reset clears the valid bits and the skid stage only; no clearing pass.
// A sink stall fills the skid stage, then freezes the whole pipe; in_ready
// is a register output and drops in the cycle after the stall.
module rgb_hsv_color_converter_top import rhc_pkg::*; #(
	parameter int FULL_SCALE = 255
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  rhc_in_t  in_data,
	output logic     out_valid,
	input  logic     out_ready,
	output rhc_out_t out_data
);

	localparam logic [FS_W-1:0]  FS  = FS_W'(FULL_SCALE);
	localparam logic [DEN_W-1:0] FSH = DEN_W'(FULL_SCALE) << 8;

	logic en, skid_full;

	// stage valid bits
	logic v_s1, v_s2, v_s3, v_s4, v_s15;
	logic v_s5 [0:DIV_LAT-1];

	rhc_in_t in_s1;
	rhc_sb_t sb_s2, sb_s3, sb_s4;
	rhc_sb_t sb_s5 [0:DIV_LAT-1];
	logic [PIX_W-1:0]  a_s2, b_s2;       // absdiff / sat, d / fraction
	logic [DEN_W-1:0]  pa_s3;
	logic [16:0]       pb_s3, pc_s3;
	logic [PIX_W-1:0]  ab_s3, d_s3;
	logic [NUM_W-1:0]  n0_s4, n1_s4, n2_s4;
	logic [DEN_W-1:0]  d0_s4, d1_s4, d2_s4;
	rhc_out_t          res_s15;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0; v_s15 <= 1'b0;
			for (int i = 0; i < DIV_LAT; i++) v_s5[i] <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5[0] <= v_s4;
			for (int i = 1; i < DIV_LAT; i++) v_s5[i] <= v_s5[i-1];
			v_s15 <= v_s5[DIV_LAT-1];
		end
	end

	// stage 2: max/min and leading component, or hue wrap and saturation clamp
	logic [PIX_W-1:0] r, g, b, mx, mn, lo, hi;
	logic [HUE_W-1:0] hw, base;
	logic [PIX_W-1:0] sc;
	rhc_sb_t          sb_n;

	always_comb begin
		r  = in_s1.in_first[7:0];
		g  = in_s1.in_second;
		b  = in_s1.in_third;
		mx = r;
		if (g > mx) mx = g;
		if (b > mx) mx = b;
		mn = r;
		if (g < mn) mn = g;
		if (b < mn) mn = b;
		if (mx == r) begin
			lo = g; hi = b; base = '0;
		end else if (mx == g) begin
			lo = b; hi = r; base = HUE_TWO;
		end else begin
			lo = r; hi = g; base = HUE_FOUR;
		end
		hw = (in_s1.in_first >= HUE_FULL) ? in_s1.in_first - HUE_FULL : in_s1.in_first;
		sc = (FS_W'(in_s1.in_second) > FS) ? PIX_W'(FS) : in_s1.in_second;
		sb_n.func     = in_s1.func;
		sb_n.zero_d   = (mx == mn);
		sb_n.zero_mx  = (mx == '0);
		sb_n.lo_ge_hi = (lo >= hi);
		sb_n.base     = base;
		sb_n.v        = (in_s1.func == FUNC_RGB2HSV) ? mx : in_s1.in_third;
		sb_n.sector   = hw[10:8];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			in_s1 <= in_data;
			sb_s2 <= sb_n;
			if (in_s1.func == FUNC_RGB2HSV) begin
				a_s2 <= (lo >= hi) ? lo - hi : hi - lo;
				b_s2 <= mx - mn;
			end else begin
				a_s2 <= sc;
				b_s2 <= hw[7:0];
			end
		end
	end

	// stage 3: first products
	always_ff @(posedge clk) begin
		if (en) begin
			sb_s3 <= sb_s2;
			ab_s3 <= a_s2;
			d_s3  <= b_s2;
			if (sb_s2.func == FUNC_RGB2HSV) begin
				pa_s3 <= DEN_W'(b_s2 * FS);
				pb_s3 <= '0;
				pc_s3 <= '0;
			end else begin
				pa_s3 <= DEN_W'(FS - FS_W'(a_s2));
				pb_s3 <= 17'(a_s2 * b_s2);
				pc_s3 <= 17'(a_s2 * (9'd256 - 9'(b_s2)));
			end
		end
	end

	// stage 4: dividends and divisors for the three divider lanes
	always_ff @(posedge clk) begin
		if (en) begin
			sb_s4 <= sb_s3;
			if (sb_s3.func == FUNC_RGB2HSV) begin
				n0_s4 <= NUM_W'(ab_s3) << 8;
				d0_s4 <= sb_s3.zero_d ? DEN_W'(1) : DEN_W'(d_s3);
				n1_s4 <= NUM_W'(pa_s3);
				d1_s4 <= sb_s3.zero_mx ? DEN_W'(1) : DEN_W'(sb_s3.v);
				n2_s4 <= '0;
				d2_s4 <= DEN_W'(1);
			end else begin
				n0_s4 <= NUM_W'(sb_s3.v * pa_s3[15:0]);
				d0_s4 <= DEN_W'(FS);
				n1_s4 <= NUM_W'(sb_s3.v * (FSH - DEN_W'(pb_s3)));
				d1_s4 <= FSH;
				n2_s4 <= NUM_W'(sb_s3.v * (FSH - DEN_W'(pc_s3)));
				d2_s4 <= FSH;
			end
		end
	end

	logic [QUO_W-1:0] q0, q1, q2;
	logic             ovf0, ovf1, ovf2;

	rhc_div #(.NW(NUM_W), .DW(DEN_W), .QW(QUO_W)) u_div0 (
		.clk(clk), .en(en), .num(n0_s4), .den(d0_s4), .quo(q0), .ovf(ovf0));
	rhc_div #(.NW(NUM_W), .DW(DEN_W), .QW(QUO_W)) u_div1 (
		.clk(clk), .en(en), .num(n1_s4), .den(d1_s4), .quo(q1), .ovf(ovf1));
	rhc_div #(.NW(NUM_W), .DW(DEN_W), .QW(QUO_W)) u_div2 (
		.clk(clk), .en(en), .num(n2_s4), .den(d2_s4), .quo(q2), .ovf(ovf2));

	always_ff @(posedge clk) begin
		if (en) begin
			sb_s5[0] <= sb_s4;
			for (int i = 1; i < DIV_LAT; i++) sb_s5[i] <= sb_s5[i-1];
		end
	end

	// stage 15: hue assembly or sector table
	rhc_sb_t          sbf;
	logic [HUE_W-1:0] qh, h;
	logic [PIX_W-1:0] s, p, qq, t;
	rhc_out_t         res_n;

	always_comb begin
		sbf = sb_s5[DIV_LAT-1];
		qh  = HUE_W'(q0);
		if (sbf.zero_d)        h = '0;
		else if (sbf.lo_ge_hi) h = sbf.base + qh;
		else if (sbf.base >= qh) h = sbf.base - qh;
		else                   h = HUE_FULL + sbf.base - qh;
		if (sbf.zero_mx)             s = '0;
		else if (ovf1 || q1[8])      s = 8'hFF;
		else                         s = q1[7:0];
		// hsv lanes never overflow: results stay at or below v
		p  = ovf0 ? 8'hFF : q0[7:0];
		qq = q1[7:0];
		t  = ovf2 ? 8'hFF : q2[7:0];
		if (sbf.func == FUNC_RGB2HSV) begin
			res_n = '{out_first: h, out_second: s, out_third: sbf.v};
		end else begin
			case (sbf.sector)
				3'd0:    res_n = '{out_first: HUE_W'(sbf.v), out_second: t, out_third: p};
				3'd1:    res_n = '{out_first: HUE_W'(qq), out_second: sbf.v, out_third: p};
				3'd2:    res_n = '{out_first: HUE_W'(p), out_second: sbf.v, out_third: t};
				3'd3:    res_n = '{out_first: HUE_W'(p), out_second: qq, out_third: sbf.v};
				3'd4:    res_n = '{out_first: HUE_W'(t), out_second: p, out_third: sbf.v};
				default: res_n = '{out_first: HUE_W'(sbf.v), out_second: p, out_third: qq};
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (en) res_s15 <= res_n;
	end

	rhc_skid u_skid (
		.clk(clk), .arst_n(arst_n),
		.pipe_valid(v_s15), .pipe_data(res_s15),
		.pipe_en(en), .full(skid_full),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	assign in_ready = en;

	// the skid stage fills only from a stalled, valid last stage
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_full) |-> $past(v_s15 && !out_ready))
		else $error("skid stage filled without a stalled word");

	a_skid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		skid_full && !out_ready |=> skid_full && $stable(out_data))
		else $error("held word lost while sink stalls");

	a_pipe_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		skid_full |=> $stable(res_s15) || !$past(v_s15))
		else $error("pipe advanced while skid stage full");

endmodule

// ===== src/rhc_div.sv =====
// ----------------------------------------------------------------------------
// rhc_div: pipelined restoring divider
// One quotient bit per stage; flags quotients that do not fit in QW bits.
// ----------------------------------------------------------------------------
module rhc_div import rhc_pkg::*; #(
	parameter int NW = 32,
	parameter int DW = 24,
	parameter int QW = 9
) (
	input  logic          clk,
	input  logic          en,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [QW-1:0] quo,
	output logic          ovf
);

	logic [DW-1:0] rem_q [0:QW];
	logic [QW-1:0] low_q [0:QW];
	logic [QW-1:0] quo_q [0:QW];
	logic [DW-1:0] den_q [0:QW];
	logic          ovf_q [0:QW];

	always_ff @(posedge clk) begin
		if (en) begin
			ovf_q[0] <= NW'(num >> QW) >= NW'(den);
			rem_q[0] <= DW'(num >> QW);
			low_q[0] <= num[QW-1:0];
			quo_q[0] <= '0;
			den_q[0] <= den;
		end
	end

	for (genvar i = 1; i <= QW; i++) begin : g_stage
		logic [DW:0] trial;
		logic        ge;
		assign trial = {rem_q[i-1], low_q[i-1][QW-i]};
		assign ge    = trial >= {1'b0, den_q[i-1]};
		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[i] <= ge ? DW'(trial - {1'b0, den_q[i-1]}) : DW'(trial);
				quo_q[i] <= {quo_q[i-1][QW-2:0], ge};
				low_q[i] <= low_q[i-1];
				den_q[i] <= den_q[i-1];
				ovf_q[i] <= ovf_q[i-1];
			end
		end
	end

	assign quo = quo_q[QW];
	assign ovf = ovf_q[QW];

endmodule

// ===== src/rhc_skid.sv =====
// ----------------------------------------------------------------------------
// rhc_skid: output skid stage
// Catches the last pipeline word when the sink stalls and freezes the pipe.
// ----------------------------------------------------------------------------
module rhc_skid import rhc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     pipe_valid,
	input  rhc_out_t pipe_data,
	output logic     pipe_en,
	output logic     full,
	output logic     out_valid,
	input  logic     out_ready,
	output rhc_out_t out_data
);

	logic     full_q;
	rhc_out_t data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
		end else if (full_q) begin
			if (out_ready) full_q <= 1'b0;
		end else if (pipe_valid && !out_ready) begin
			full_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!full_q) data_q <= pipe_data;
	end

	assign pipe_en   = !full_q;
	assign full      = full_q;
	assign out_valid = full_q || pipe_valid;
	assign out_data  = full_q ? data_q : pipe_data;

endmodule
